// ----- sv/parp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package parp_pkg;

  localparam int unsigned Sessions = 64;
  localparam int unsigned IdxW = (Sessions > 1) ? $clog2(Sessions) : 1;
  localparam int unsigned CntW = $clog2(Sessions + 1);

  localparam int unsigned InW  = 224;
  localparam int unsigned OutW = 160;

  // item kinds carried on the input tuser
  localparam logic OpPacket     = 1'b0;
  localparam logic OpTableWrite = 1'b1;

  localparam logic [15:0] OpcRequest = 16'd1;
  localparam logic [15:0] OpcReply   = 16'd2;
  localparam logic [15:0] ProtoIpv4  = 16'h0800;
  localparam logic [7:0]  HwLenEth   = 8'd6;
  localparam logic [7:0]  ProtoLenIp = 8'd4;
  localparam logic [47:0] MacBcast   = 48'hFFFF_FFFF_FFFF;

  localparam int unsigned FlagValid   = 0;
  localparam int unsigned FlagActive  = 1;
  localparam int unsigned FlagPending = 2;

  localparam logic [1:0] CfgArpMode     = 2'd0;
  localparam logic [1:0] CfgPuntUnknown = 2'd1;
  localparam logic [1:0] CfgOwnMac      = 2'd2;

  localparam logic [1:0] ModeOff         = 2'd0;
  localparam logic [1:0] ModeUnknownOnly = 2'd1;
  localparam logic [1:0] ModeSessionMac  = 2'd2;
  localparam logic [1:0] ModeOwnMac      = 2'd3;

  typedef enum logic [1:0] {
    ActDrop  = 2'd0,
    ActReply = 2'd1,
    ActPunt  = 2'd2
  } action_e;

  // last field in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [2:0]  entry_flags;
    logic [5:0]  entry_index;
    logic [47:0] link_src_mac;
    logic [31:0] target_ip;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [7:0]  proto_len;
    logic [7:0]  hw_len;
    logic [15:0] proto_type;
    logic [15:0] arp_opcode;
  } pkt_t;

  typedef struct packed {
    logic [31:0] reply_target_ip;
    logic [31:0] reply_sender_ip;
    logic [47:0] reply_sender_mac;
    logic [47:0] reply_dest_mac;
  } reply_t;

  typedef struct packed {
    logic capture;
    logic mem_write;
    logic scan_clear;
    logic scan_run;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_write;
    logic pre_done;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- sv/parp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module parp_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire parp_pkg::sts_t  sts_i,
  output parp_pkg::cmd_t       cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StCheck  = 2'd1;
  localparam logic [1:0] StScan   = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = StCheck;
      end
      StCheck: begin
        if (sts_i.is_write) begin
          cmd_o.mem_write = 1'b1;
          state_d         = StFinish;
        end else if (sts_i.pre_done) begin
          state_d = StFinish;
        end else begin
          cmd_o.scan_clear = 1'b1;
          state_d          = StScan;
        end
      end
      StScan: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) state_d = StFinish;
      end
      StFinish: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/parp_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module parp_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [parp_pkg::InW-1:0]     in_data_i,
  input  wire logic                         in_op_i,
  input  wire logic                         cfg_valid_i,
  input  wire logic [1:0]                   cfg_index_i,
  input  wire logic [47:0]                  cfg_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [parp_pkg::OutW-1:0]         out_data_o,
  output logic [1:0]                        out_action_o,
  input  wire parp_pkg::cmd_t               cmd_i,
  output parp_pkg::sts_t                    sts_o
);

  typedef struct packed {
    logic [2:0]  flags;
    logic [47:0] mac;
    logic [31:0] ip;
  } sess_t;

  // config
  logic [1:0]  arp_mode_q;
  logic        punt_q;
  logic [47:0] own_mac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arp_mode_q <= parp_pkg::ModeOff;
      punt_q     <= 1'b0;
      own_mac_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        parp_pkg::CfgArpMode:     arp_mode_q <= cfg_data_i[1:0];
        parp_pkg::CfgPuntUnknown: punt_q     <= cfg_data_i[0];
        parp_pkg::CfgOwnMac:      own_mac_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured item
  parp_pkg::pkt_t cap_q;
  logic           cap_op_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cap_q    <= parp_pkg::pkt_t'(in_data_i);
      cap_op_q <= in_op_i;
    end
  end

  // header checks
  logic opc_ok, hdr_ok, pre_drop, is_reply;

  always_comb begin
    opc_ok = (cap_q.arp_opcode == parp_pkg::OpcRequest) ||
             ((cap_q.arp_opcode == parp_pkg::OpcReply) &&
              (cap_q.link_src_mac == parp_pkg::MacBcast));
    hdr_ok = (cap_q.proto_len == parp_pkg::ProtoLenIp) &&
             (cap_q.proto_type == parp_pkg::ProtoIpv4) &&
             (cap_q.hw_len == parp_pkg::HwLenEth) &&
             (cap_q.sender_mac == cap_q.link_src_mac) &&
             (cap_q.sender_ip != 32'd0) &&
             (cap_q.sender_ip != cap_q.target_ip);
    pre_drop = !(opc_ok && hdr_ok);
    is_reply = cap_q.arp_opcode == parp_pkg::OpcReply;
  end

  // session table; a slot reads as empty until written
  sess_t                          mem [parp_pkg::Sessions];
  logic [parp_pkg::Sessions-1:0]  written_q;
  logic                           wr_en;
  logic [parp_pkg::IdxW-1:0]      wr_addr;

  assign wr_en   = cmd_i.mem_write &&
                   (32'(cap_q.entry_index) < parp_pkg::Sessions);
  assign wr_addr = parp_pkg::IdxW'(cap_q.entry_index);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= '{flags: cap_q.entry_flags, mac: cap_q.sender_mac,
                        ip: cap_q.sender_ip};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_en) begin
      written_q[wr_addr] <= 1'b1;
    end
  end

  // scan: read slot n while slot n-1 is compared
  logic [parp_pkg::CntW-1:0] rd_cnt_q;
  logic [parp_pkg::IdxW-1:0] rd_addr, rd_idx_q;
  logic                      rd_vld_q, rd_wr_q, rd_issue;
  sess_t                     rd_q;

  assign rd_addr  = rd_cnt_q[parp_pkg::IdxW-1:0];
  assign rd_issue = cmd_i.scan_run &&
                    (rd_cnt_q < parp_pkg::CntW'(parp_pkg::Sessions));

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      rd_q     <= mem[rd_addr];
      rd_wr_q  <= written_q[rd_addr];
      rd_idx_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.scan_clear) begin
      rd_cnt_q <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.scan_run) begin
      rd_vld_q <= rd_issue;
      if (rd_issue) rd_cnt_q <= rd_cnt_q + 1'b1;
    end
  end

  logic [2:0] ent_f;
  logic       hit_s, hit_t, s1f_nx, s2f_nx, stop, rd_last;
  logic       s1f_q, s1_pend_q, s2f_q, s2_act_q;
  logic [47:0] s2_mac_q;

  always_comb begin
    ent_f   = rd_wr_q ? rd_q.flags : 3'b000;
    hit_s   = rd_vld_q && ent_f[parp_pkg::FlagValid] && (rd_q.ip == cap_q.sender_ip);
    hit_t   = rd_vld_q && ent_f[parp_pkg::FlagValid] && (rd_q.ip == cap_q.target_ip);
    s1f_nx  = s1f_q || hit_s;
    s2f_nx  = s2f_q || hit_t;
    // an inactive match ends the scan, as does having both sessions
    stop    = ((hit_s || hit_t) && !ent_f[parp_pkg::FlagActive]) || (s1f_nx && s2f_nx);
    rd_last = rd_idx_q == parp_pkg::IdxW'(parp_pkg::Sessions - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1f_q <= 1'b0;
      s2f_q <= 1'b0;
    end else if (cmd_i.scan_clear) begin
      s1f_q <= 1'b0;
      s2f_q <= 1'b0;
    end else if (cmd_i.scan_run) begin
      s1f_q <= s1f_nx;
      s2f_q <= s2f_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_run && hit_s) begin
      s1_pend_q <= ent_f[parp_pkg::FlagPending];
    end
    if (cmd_i.scan_run && hit_t) begin
      s2_act_q <= ent_f[parp_pkg::FlagActive];
      s2_mac_q <= rd_q.mac;
    end
  end

  // decision
  parp_pkg::action_e act;
  logic [47:0]       announce;

  always_comb begin
    announce = own_mac_q;
    if (s2f_q && (arp_mode_q == parp_pkg::ModeSessionMac)) announce = s2_mac_q;
    if (cap_op_q == parp_pkg::OpTableWrite || pre_drop) begin
      act = parp_pkg::ActDrop;
    end else if (is_reply) begin
      act = parp_pkg::ActPunt;
    end else if (!s1f_q && punt_q) begin
      act = parp_pkg::ActPunt;
    end else if ((arp_mode_q == parp_pkg::ModeOff) || !s1f_q || s1_pend_q ||
                 (s2f_q && !s2_act_q)) begin
      act = parp_pkg::ActDrop;
    end else if (s2f_q && (arp_mode_q == parp_pkg::ModeUnknownOnly)) begin
      act = parp_pkg::ActDrop;
    end else begin
      act = parp_pkg::ActReply;
    end
  end

  // output register
  logic              out_vld_q;
  parp_pkg::action_e out_act_q;
  parp_pkg::reply_t  out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_act_q <= act;
      if (act == parp_pkg::ActReply) begin
        out_q <= '{reply_target_ip: cap_q.sender_ip, reply_sender_ip: cap_q.target_ip,
                   reply_sender_mac: announce, reply_dest_mac: cap_q.sender_mac};
      end else begin
        out_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_data_o   = out_q;
  assign out_action_o = out_act_q;

  assign sts_o.is_write  = cap_op_q == parp_pkg::OpTableWrite;
  assign sts_o.pre_done  = pre_drop || is_reply;
  assign sts_o.scan_done = rd_vld_q && (stop || rd_last);
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

endmodule
`default_nettype wire

// ----- sv/proxy_arp_responder_unit.sv -----
// A table write, a dropped header or an ARP reply passes the capture register, the
// check and finish states and the output register; a request also scans the session
// table (one slot compared per cycle over 64 slots, less on an early stop).
// One item at a time: the next is taken only after the output load; a stall delays it.
// Reset: config registers zero, session table empty (per-slot written bits cleared).
`timescale 1ns / 1ps
`default_nettype none
module proxy_arp_responder_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // arp_opcode, proto_type, hw_len, proto_len, sender_mac, sender_ip,
  // target_ip, link_src_mac, entry_index, entry_flags, zero pad
  input  wire logic [parp_pkg::InW-1:0]  s_axis_tdata,
  // op
  input  wire logic                      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // reply_dest_mac, reply_sender_mac, reply_sender_ip, reply_target_ip
  output logic [parp_pkg::OutW-1:0]      m_axis_tdata,
  // action
  output logic [1:0]                     m_axis_tuser,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [1:0]                cfg_index_i,
  input  wire logic [47:0]               cfg_data_i
);

  parp_pkg::cmd_t cmd;
  parp_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  parp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  parp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_data_i    (s_axis_tdata),
    .in_op_i      (s_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_action_o (m_axis_tuser),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  a_no_reply_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != parp_pkg::ActReply) |-> m_axis_tdata == '0)
    else $error("reply fields nonzero on drop or punt");

  a_action_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == parp_pkg::ActDrop) ||
                      (m_axis_tuser == parp_pkg::ActReply) ||
                      (m_axis_tuser == parp_pkg::ActPunt))
    else $error("undefined action code");

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import parp_pkg::*;

  typedef struct {
    logic op;
    pkt_t pkt;
  } arp_item_t;

  typedef struct {
    action_e act;
    reply_t  rep;
  } arp_result_t;

  localparam int PoolSize = 12;
  localparam int PhaseItems = 175;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata = '0;
  logic            s_axis_tuser = 1'b0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  logic [1:0]      m_axis_tuser;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [1:0]      cfg_index_i = '0;
  logic [47:0]     cfg_data_i = '0;

  proxy_arp_responder_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // shadow of the session table and the registers
  logic [31:0] slot_ip    [Sessions];
  logic [47:0] slot_mac   [Sessions];
  logic [2:0]  slot_flags [Sessions];
  logic [1:0]  mode_q = ModeOff;
  logic        punt_q = 1'b0;
  logic [47:0] own_mac_q = '0;

  arp_item_t   pending_q[$];
  arp_result_t reply_q[$];
  logic [31:0] ip_pool [PoolSize];

  int n_queued = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic in_taken = 1'b0;
  bit hold_armed = 0;
  bit hold_done = 0;
  int hold_left = 0;

  arp_result_t mon_want;
  reply_t      mon_got;
  arp_item_t   drv_item;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < Sessions; i++) begin
      slot_ip[i] = '0;
      slot_mac[i] = '0;
      slot_flags[i] = '0;
    end
  end

  function automatic arp_result_t predict_arp(arp_item_t it);
    arp_result_t res;
    pkt_t p;
    int src_slot;
    int dst_slot;
    int i;
    logic [47:0] announce;
    p = it.pkt;
    res.act = ActDrop;
    res.rep = '0;
    src_slot = -1;
    dst_slot = -1;
    if (it.op == OpTableWrite) begin
      if (p.entry_index < Sessions) begin
        slot_ip[p.entry_index] = p.sender_ip;
        slot_mac[p.entry_index] = p.sender_mac;
        slot_flags[p.entry_index] = p.entry_flags;
      end
      return res;
    end
    // a reply is only taken when it came from the broadcast address
    if (p.arp_opcode != OpcRequest &&
        (p.arp_opcode != OpcReply || p.link_src_mac != MacBcast)) return res;
    if (p.proto_len != ProtoLenIp || p.proto_type != ProtoIpv4 || p.hw_len != HwLenEth ||
        p.sender_mac != p.link_src_mac || p.sender_ip == '0) return res;
    if (p.sender_ip == p.target_ip) return res;
    if (p.arp_opcode == OpcReply) begin
      res.act = ActPunt;
      return res;
    end
    // a later valid match replaces an earlier one; an inactive match ends the scan at once
    for (i = 0; i < Sessions; i++) begin
      if (!slot_flags[i][FlagValid]) continue;
      if (slot_ip[i] == p.sender_ip) begin
        src_slot = i;
        if (!slot_flags[i][FlagActive]) break;
      end
      if (slot_ip[i] == p.target_ip) begin
        dst_slot = i;
        if (!slot_flags[i][FlagActive]) break;
      end
      if (src_slot >= 0 && dst_slot >= 0) break;
    end
    if (src_slot < 0 && punt_q) begin
      res.act = ActPunt;
      return res;
    end
    if (mode_q == ModeOff || src_slot < 0 || slot_flags[src_slot][FlagPending] ||
        (dst_slot >= 0 && !slot_flags[dst_slot][FlagActive])) return res;
    if (dst_slot >= 0) begin
      if (mode_q == ModeUnknownOnly) return res;
      announce = (mode_q == ModeSessionMac) ? slot_mac[dst_slot] : own_mac_q;
    end else begin
      announce = own_mac_q;
    end
    res.act = ActReply;
    res.rep.reply_dest_mac = p.sender_mac;
    res.rep.reply_sender_mac = announce;
    res.rep.reply_sender_ip = p.target_ip;
    res.rep.reply_target_ip = p.sender_ip;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (n_errors < 100) $display("mismatch %s: got %h want %h", what, got, want);
    n_errors++;
  endtask

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 99) < 85) return ip_pool[$urandom_range(0, PoolSize - 1)];
    return $urandom;
  endfunction

  function automatic arp_item_t mk_req(logic [31:0] sip, logic [31:0] tip);
    arp_item_t it;
    it.op = OpPacket;
    it.pkt = '0;
    it.pkt.arp_opcode = OpcRequest;
    it.pkt.proto_type = ProtoIpv4;
    it.pkt.hw_len = HwLenEth;
    it.pkt.proto_len = ProtoLenIp;
    it.pkt.sender_mac = rand_mac();
    it.pkt.link_src_mac = it.pkt.sender_mac;
    it.pkt.sender_ip = sip;
    it.pkt.target_ip = tip;
    it.pkt.entry_index = 6'($urandom);
    it.pkt.entry_flags = 3'($urandom);
    return it;
  endfunction

  function automatic arp_item_t mk_write(logic [5:0] idx, logic [31:0] ip, logic [2:0] flags);
    arp_item_t it;
    it.op = OpTableWrite;
    it.pkt = '0;
    it.pkt.arp_opcode = 16'($urandom);
    it.pkt.proto_type = 16'($urandom);
    it.pkt.hw_len = 8'($urandom);
    it.pkt.proto_len = 8'($urandom);
    it.pkt.sender_mac = rand_mac();
    it.pkt.sender_ip = ip;
    it.pkt.target_ip = $urandom;
    it.pkt.link_src_mac = rand_mac();
    it.pkt.entry_index = idx;
    it.pkt.entry_flags = flags;
    return it;
  endfunction

  function automatic arp_item_t gen_item();
    arp_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) begin
      it = mk_write(6'($urandom), pick_ip(),
                    ($urandom_range(0, 3) == 0) ? 3'($urandom) : (3'($urandom) | 3'b001));
    end else if (r < 72) begin
      it = mk_req(pick_ip(), pick_ip());
    end else if (r < 80) begin
      it = mk_req(pick_ip(), pick_ip());
      it.pkt.arp_opcode = OpcReply;
      if ($urandom_range(0, 3) != 0) begin
        it.pkt.sender_mac = MacBcast;
        it.pkt.link_src_mac = MacBcast;
      end
    end else begin
      it = mk_req(pick_ip(), pick_ip());
      case ($urandom_range(0, 7))
        0: it.pkt.arp_opcode = 16'($urandom);
        1: it.pkt.proto_type = 16'($urandom);
        2: it.pkt.hw_len = 8'($urandom);
        3: it.pkt.proto_len = 8'($urandom);
        4: it.pkt.link_src_mac = rand_mac();
        5: it.pkt.sender_ip = '0;
        6: it.pkt.target_ip = it.pkt.sender_ip;
        default: begin
          it.pkt.arp_opcode = 16'($urandom);
          it.pkt.proto_type = 16'($urandom);
          it.pkt.hw_len = 8'($urandom);
          it.pkt.proto_len = 8'($urandom);
          it.pkt.sender_mac = rand_mac();
          it.pkt.sender_ip = $urandom;
          it.pkt.target_ip = $urandom;
          it.pkt.link_src_mac = rand_mac();
        end
      endcase
    end
    return it;
  endfunction

  task automatic push_item(arp_item_t it);
    pending_q.push_back(it);
    n_queued++;
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || reply_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [47:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgArpMode:     mode_q = val[1:0];
      CfgPuntUnknown: punt_q = val[0];
      CfgOwnMac:      own_mac_q = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(logic [1:0] mode, logic punt, logic [47:0] mac);
    cfg_write(CfgArpMode, {46'd0, mode});
    cfg_write(CfgPuntUnknown, {47'd0, punt});
    cfg_write(CfgOwnMac, mac);
  endtask

  task automatic run_phase(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int k = 0; k < PhaseItems; k++) push_item(gen_item());
    wait_idle();
  endtask

  // sender: holds an item until it is taken, then maybe idles
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (pending_q.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
        drv_item = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= drv_item.pkt;
        s_axis_tuser <= drv_item.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_armed && !hold_done) begin
      hold_left = 300;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (reply_q.size() == 0) begin
          report_mismatch("unexpected item", 64'(m_axis_tdata), '0);
        end else begin
          mon_want = reply_q.pop_front();
          mon_got = reply_t'(m_axis_tdata);
          if (m_axis_tuser !== mon_want.act)
            report_mismatch("action", 64'(m_axis_tuser), 64'(mon_want.act));
          if (mon_got.reply_dest_mac !== mon_want.rep.reply_dest_mac)
            report_mismatch("reply_dest_mac", 64'(mon_got.reply_dest_mac),
                            64'(mon_want.rep.reply_dest_mac));
          if (mon_got.reply_sender_mac !== mon_want.rep.reply_sender_mac)
            report_mismatch("reply_sender_mac", 64'(mon_got.reply_sender_mac),
                            64'(mon_want.rep.reply_sender_mac));
          if (mon_got.reply_sender_ip !== mon_want.rep.reply_sender_ip)
            report_mismatch("reply_sender_ip", 64'(mon_got.reply_sender_ip),
                            64'(mon_want.rep.reply_sender_ip));
          if (mon_got.reply_target_ip !== mon_want.rep.reply_target_ip)
            report_mismatch("reply_target_ip", 64'(mon_got.reply_target_ip),
                            64'(mon_want.rep.reply_target_ip));
        end
      end
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        reply_q.push_back(predict_arp('{op: s_axis_tuser, pkt: pkt_t'(s_axis_tdata)}));
        n_accepted++;
      end
    end
  end

  initial begin
    arp_item_t it;
    for (int i = 0; i < PoolSize; i++) ip_pool[i] = ($urandom & 32'hFFFF_FF00) | 32'(i + 1);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part: A..F are pool[0..5]; F never gets a slot
    set_config(ModeSessionMac, 1'b0, rand_mac());
    push_item(mk_write(6'd0, ip_pool[0], 3'b011));
    push_item(mk_write(6'd63, ip_pool[1], 3'b011));
    push_item(mk_write(6'd5, ip_pool[2], 3'b111));
    push_item(mk_write(6'd7, ip_pool[3], 3'b001));
    push_item(mk_write(6'd9, ip_pool[4], 3'b000));
    push_item(mk_req(ip_pool[0], ip_pool[1]));   // known target, session MAC
    push_item(mk_req(ip_pool[0], ip_pool[5]));   // unknown target, own MAC
    push_item(mk_req(ip_pool[2], ip_pool[0]));   // pending sender
    push_item(mk_req(ip_pool[0], ip_pool[3]));   // inactive target
    push_item(mk_req(ip_pool[5], ip_pool[0]));   // unknown sender, no punt
    push_item(mk_req(ip_pool[4], ip_pool[0]));   // sender slot not valid
    push_item(mk_req(ip_pool[0], ip_pool[0]));   // self query
    // inactive sender in slot 7 stops the scan before slot 63
    push_item(mk_req(ip_pool[3], ip_pool[1]));
    it = mk_req(ip_pool[0], ip_pool[1]);
    it.pkt.arp_opcode = 16'hFFFF;
    push_item(it);
    it = mk_req(ip_pool[0], ip_pool[1]);
    it.pkt.arp_opcode = OpcReply;
    it.pkt.sender_mac = MacBcast;
    it.pkt.link_src_mac = MacBcast;
    push_item(it);                                // broadcast reply, punted
    it.pkt.link_src_mac = 48'h0;
    push_item(it);                                // reply not from broadcast
    it = mk_req(ip_pool[0], ip_pool[1]);
    it.pkt.proto_type = 16'h86DD;
    push_item(it);
    it = mk_req(ip_pool[0], ip_pool[1]);
    it.pkt.hw_len = 8'hFF;
    push_item(it);
    it = mk_req(ip_pool[0], ip_pool[1]);
    it.pkt.proto_len = 8'd16;
    push_item(it);
    it = mk_req(ip_pool[0], ip_pool[1]);
    it.pkt.link_src_mac = ~it.pkt.sender_mac;
    push_item(it);
    push_item(mk_req(32'h0, ip_pool[1]));
    it.op = OpPacket;
    it.pkt = '1;
    it.pkt.pad = '0;
    push_item(it);
    it.pkt = '0;
    push_item(it);
    wait_idle();

    set_config(ModeOwnMac, 1'b1, 48'h0);
    hold_armed = 1;
    run_phase(0, 0);
    set_config(ModeUnknownOnly, 1'b0, MacBcast);
    run_phase(85, 0);
    set_config(ModeOff, 1'b1, rand_mac());
    run_phase(0, 85);
    set_config(ModeSessionMac, 1'b0, rand_mac());
    run_phase(37, 37);

    repeat (80) @(negedge clk_i);
    if (n_errors == 0 && reply_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
